>>> hdl/slip_frame_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// SLIP frame decoder assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_UNIT_DEFINES_SVH
`define SLIP_FRAME_DECODER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define SFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Framing byte codes, result kinds and the result record type.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int PKT_LEN_W = 11;

    // SLIP special bytes
    localparam logic [BYTE_W-1:0] SLIP_END     = 8'o300;
    localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'o333;
    localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'o334;
    localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'o335;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVER = 2'd2;

    // Reset value of the length limit
    localparam logic [PKT_LEN_W-1:0] MAX_LENGTH_RESET = 11'd1024;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data;
        logic [PKT_LEN_W-1:0] packet_length;
    } result_t;

endpackage

>>> hdl/sfd_decode.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder core
// Holds framing state and decodes one registered byte per cycle when advance is high.
// ----------------------------------------------------------------------------
module sfd_decode #(
    parameter int CNT_W = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [sfd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        advance,
    input  logic [CNT_W-1:0]            limit,
    output logic                        res_valid,
    output sfd_pkg::result_t            res
);
    import sfd_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Next state and result for the byte at the input register
    always_comb begin
        logic              is_data;
        logic [BYTE_W-1:0] val;
        in_frame_next     = in_frame_reg;
        esc_next          = esc_reg;
        count_next        = count_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_DATA;
        res.data          = '0;
        res.packet_length = '0;
        is_data           = 1'b0;
        val               = in_byte;
        if (!in_frame_reg) begin
            // hunting: an escape also swallows the byte after it
            if (esc_reg) begin
                esc_next = 1'b0;
            end else if (in_byte == SLIP_ESC) begin
                esc_next = 1'b1;
            end else if (in_byte == SLIP_END) begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end
        end else begin
            if (esc_reg) begin
                esc_next = 1'b0;
                is_data  = 1'b1;
                if (in_byte == SLIP_ESC_END) begin
                    val = SLIP_END;
                end else if (in_byte == SLIP_ESC_ESC) begin
                    val = SLIP_ESC;
                end
            end else if (in_byte == SLIP_ESC) begin
                esc_next = 1'b1;
            end else if (in_byte == SLIP_END) begin
                // empty packets are skipped
                if (count_reg != '0) begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_END;
                    res.packet_length = PKT_LEN_W'(count_reg);
                    count_next        = '0;
                end
            end else begin
                is_data = 1'b1;
            end
            if (is_data) begin
                res_valid = 1'b1;
                if (count_reg >= limit) begin
                    // overflow: drop byte, go back to hunting
                    res.kind          = KIND_OVER;
                    res.packet_length = PKT_LEN_W'(count_reg);
                    count_next        = '0;
                    esc_next          = 1'b0;
                    in_frame_next     = 1'b0;
                end else begin
                    count_next        = CNT_W'(count_reg + 1'b1);
                    res.kind          = KIND_DATA;
                    res.data          = val;
                    res.packet_length = PKT_LEN_W'(count_next);
                end
            end
        end
        res_valid = res_valid & in_valid;
    end

    // State commits when the byte leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
        end else if (advance) begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
        end
    end

endmodule

>>> hdl/sfd_out_reg.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sfd_pkg::result_t  load_res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output sfd_pkg::result_t  m_res
);
    import sfd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Room for a new result when empty or being drained this cycle
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (free && load) begin
            res_reg <= load_res;
        end
    end

endmodule

>>> hdl/slip_frame_decoder_unit.sv
// A result is registered: an accepted byte passes the input register, the decode core and the result register.
// Throughput: one byte per cycle unless stalled; the input register drains
// when its byte gives no result or the result register is empty or taken.
// Reset (aresetn low, synchronous): hunting for END, no escape, count zero,
// max_length back to 1024, both registers empty. No clearing pass.
// ----------------------------------------------------------------------------
// SLIP frame decoder top level
// Input byte register, framing decode core and result register.
// ----------------------------------------------------------------------------
`include "slip_frame_decoder_unit_defines.svh"

module slip_frame_decoder_unit #(
    parameter int MAX_PACKET = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]     s_in_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sfd_pkg::KIND_W-1:0]     m_kind,
    output logic [sfd_pkg::BYTE_W-1:0]     m_data,
    output logic [sfd_pkg::PKT_LEN_W-1:0]  m_packet_length,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfd_pkg::PKT_LEN_W-1:0]  cfg_data
);
    import sfd_pkg::*;

    // Counter never needs more than the length field width
    localparam int CNT_RAW_W = $clog2(MAX_PACKET + 1);
    localparam int CNT_W     = (CNT_RAW_W > PKT_LEN_W) ? PKT_LEN_W : CNT_RAW_W;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic [PKT_LEN_W-1:0] max_length_reg;
    logic [CNT_W-1:0]     limit;
    logic                 res_valid;
    result_t              res;
    result_t              out_res;
    logic                 out_free;
    logic                 step;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (cfg_valid) begin
            max_length_reg <= cfg_data;
        end
    end

    // Effective limit, clamped to the packet buffer size
    assign limit = (32'(max_length_reg) > 32'(MAX_PACKET)) ? CNT_W'(MAX_PACKET)
                                                           : CNT_W'(max_length_reg);

    // Input register advances when its result has somewhere to go
    assign step    = in_valid_reg && (!res_valid || out_free);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    sfd_decode #(
        .CNT_W (CNT_W)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .advance   (step),
        .limit     (limit),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .load_res (res),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_kind          = out_res.kind;
    assign m_data          = out_res.data;
    assign m_packet_length = out_res.packet_length;

    // Checks
    `SFD_ASSERT_ALWAYS(a_data_zero, !m_valid || m_kind == KIND_DATA || m_data == '0, "data not zero on non-data result")
    `SFD_ASSERT_ALWAYS(a_len_nonzero, !m_valid || m_kind == KIND_OVER || m_packet_length != '0, "zero length on data or end result")
    `SFD_ASSERT_NEXT(a_in_hold, in_valid_reg && !step, in_valid_reg && $stable(in_byte_reg), "stalled input byte lost")
    `SFD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_res), "stalled result changed")

endmodule
